// ----- src/pfrgba_pkg.sv -----
// ----------------------------------------------------------------------------
// pfrgba_pkg
// Shared widths, codes, result record and colour expansion tables for the
// pixel format to RGBA8 converter.
// ----------------------------------------------------------------------------
package pfrgba_pkg;

  localparam int BYTE_W      = 8;
  localparam int FMT_W       = 4;
  localparam int DIM_W       = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int WORD_W      = 32;
  localparam int GATHER_W    = 24;
  localparam int DEFAULT_MAX_DIMENSION = 4096;

  // Source format codes; every other code is unsupported.
  typedef enum logic [FMT_W-1:0] {
    FMT_BGRA     = 4'd0,
    FMT_RGBA     = 4'd1,
    FMT_ABGR     = 4'd2,
    FMT_ARGB     = 4'd3,
    FMT_BGR      = 4'd4,
    FMT_RGB      = 4'd5,
    FMT_R5G6B5   = 4'd6,
    FMT_A4R4G4B4 = 4'd7
  } fmt_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_FORMAT = 2'd0,
    REG_IMAGE_WIDTH   = 2'd1,
    REG_IMAGE_HEIGHT  = 2'd2
  } reg_idx_t;

  // One converted pixel.
  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic              last_pixel;
    logic              format_error;
  } pixel_t;

  // Expansion of a 5-bit channel: floor(v * 255 / 31), built at elaboration.
  function automatic logic [32*BYTE_W-1:0] build_exp5();
    logic [32*BYTE_W-1:0] tbl;
    tbl = '0;
    for (int i = 0; i < 32; i++) begin
      tbl[i*BYTE_W +: BYTE_W] = BYTE_W'((i * 255) / 31);
    end
    return tbl;
  endfunction

  // Expansion of a 6-bit channel: floor(v * 255 / 63), built at elaboration.
  function automatic logic [64*BYTE_W-1:0] build_exp6();
    logic [64*BYTE_W-1:0] tbl;
    tbl = '0;
    for (int i = 0; i < 64; i++) begin
      tbl[i*BYTE_W +: BYTE_W] = BYTE_W'((i * 255) / 63);
    end
    return tbl;
  endfunction

  localparam logic [32*BYTE_W-1:0] EXP5_TABLE = build_exp5();
  localparam logic [64*BYTE_W-1:0] EXP6_TABLE = build_exp6();

endpackage

// ----- src/pfrgba_unpack.sv -----
// ----------------------------------------------------------------------------
// pfrgba_unpack
// Turns one assembled source word into an RGBA8 pixel according to the
// configured source format.
// ----------------------------------------------------------------------------
module pfrgba_unpack (
  input  logic [pfrgba_pkg::FMT_W-1:0]  source_format,
  input  logic [pfrgba_pkg::WORD_W-1:0] word,
  input  logic                          last_pixel,
  output pfrgba_pkg::pixel_t            pixel
);

  logic [4:0] r5;
  logic [5:0] g6;
  logic [4:0] b5;

  // Channel fields of the 16-bit little-endian R5G6B5 word.
  assign b5 = word[4:0];
  assign g6 = word[10:5];
  assign r5 = word[15:11];

  // Channel selection and expansion per format.
  always_comb begin
    pixel              = '0;
    pixel.alpha        = 8'hFF;
    pixel.last_pixel   = last_pixel;
    pixel.format_error = 1'b0;
    unique case (source_format)
      pfrgba_pkg::FMT_BGRA: begin
        pixel.red   = word[23:16];
        pixel.green = word[15:8];
        pixel.blue  = word[7:0];
        pixel.alpha = word[31:24];
      end
      pfrgba_pkg::FMT_RGBA: begin
        pixel.red   = word[7:0];
        pixel.green = word[15:8];
        pixel.blue  = word[23:16];
        pixel.alpha = word[31:24];
      end
      pfrgba_pkg::FMT_ABGR: begin
        pixel.red   = word[31:24];
        pixel.green = word[23:16];
        pixel.blue  = word[15:8];
        pixel.alpha = word[7:0];
      end
      pfrgba_pkg::FMT_ARGB: begin
        pixel.red   = word[15:8];
        pixel.green = word[23:16];
        pixel.blue  = word[31:24];
        pixel.alpha = word[7:0];
      end
      pfrgba_pkg::FMT_BGR: begin
        pixel.red   = word[23:16];
        pixel.green = word[15:8];
        pixel.blue  = word[7:0];
      end
      pfrgba_pkg::FMT_RGB: begin
        pixel.red   = word[7:0];
        pixel.green = word[15:8];
        pixel.blue  = word[23:16];
      end
      pfrgba_pkg::FMT_R5G6B5: begin
        pixel.red   = pfrgba_pkg::EXP5_TABLE[r5*pfrgba_pkg::BYTE_W +: pfrgba_pkg::BYTE_W];
        pixel.green = pfrgba_pkg::EXP6_TABLE[g6*pfrgba_pkg::BYTE_W +: pfrgba_pkg::BYTE_W];
        pixel.blue  = pfrgba_pkg::EXP5_TABLE[b5*pfrgba_pkg::BYTE_W +: pfrgba_pkg::BYTE_W];
      end
      pfrgba_pkg::FMT_A4R4G4B4: begin
        // Multiplying a nibble by 17 is the nibble written twice.
        pixel.blue  = {word[3:0],   word[3:0]};
        pixel.green = {word[7:4],   word[7:4]};
        pixel.red   = {word[11:8],  word[11:8]};
        pixel.alpha = {word[15:12], word[15:12]};
      end
      default: begin
        pixel              = '0;
        pixel.format_error = 1'b1;
      end
    endcase
  end

endmodule

// ----- src/pfrgba_outbuf.sv -----
// ----------------------------------------------------------------------------
// pfrgba_outbuf
// Output register with a skid entry, so that the input side sees only a
// registered stall.
// ----------------------------------------------------------------------------
module pfrgba_outbuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pfrgba_pkg::pixel_t push_data,
  input  logic               out_stall,
  output logic               out_valid,
  output pfrgba_pkg::pixel_t out_data,
  output logic               full
);

  logic               skid_valid;
  pfrgba_pkg::pixel_t skid_data;
  logic               out_free;

  // The output register can load when empty or when its transaction completes.
  assign out_free = !out_valid || !out_stall;
  assign full     = skid_valid;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid  <= skid_valid || push;
        skid_valid <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ----- src/pixel_format_to_rgba8_top.sv -----
// ----------------------------------------------------------------------------
// pixel_format_to_rgba8_top
// Texture byte stream to RGBA8 pixel converter.
//
// The input channel (in_valid, in_stall, in_byte) takes one source byte per
// transaction. Bytes are gathered into a pixel of 4, 3 or 2 bytes depending on
// source_format; the final byte of a pixel produces one result transaction on
// the output channel (out_valid, out_stall, red, green, blue, alpha,
// last_pixel, format_error). With an unsupported format every byte produces
// a result with format_error set and zero colours.
// Each result is registered. Throughput: one byte per cycle while in_stall
// is low, set by the single pass from the gather register through the
// unpacker into the output register.
// last_pixel marks pixel number width*height; the count then restarts.
// The configuration port (cfg_write, cfg_index, cfg_data) writes a register
// at once; any write drops a partly gathered pixel and restarts the count.
// Reset selects RGBA, a 1x1 image and an empty output.
// When the receiver stalls, one further result is held in a skid entry, after
// which in_stall rises until the output drains.
// ----------------------------------------------------------------------------
module pixel_format_to_rgba8_top #(
  parameter int MAX_DIMENSION = pfrgba_pkg::DEFAULT_MAX_DIMENSION
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pfrgba_pkg::BYTE_W-1:0]    in_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pfrgba_pkg::BYTE_W-1:0]    red,
  output logic [pfrgba_pkg::BYTE_W-1:0]    green,
  output logic [pfrgba_pkg::BYTE_W-1:0]    blue,
  output logic [pfrgba_pkg::BYTE_W-1:0]    alpha,
  output logic                             last_pixel,
  output logic                             format_error,
  input  logic                             cfg_write,
  input  logic [pfrgba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfrgba_pkg::DIM_W-1:0]     cfg_data
);

  localparam int DIM_LIMIT = (1 << pfrgba_pkg::DIM_W) - 1;
  localparam int DIM_CAP   = (MAX_DIMENSION > DIM_LIMIT) ? DIM_LIMIT : MAX_DIMENSION;
  localparam longint TOTAL_MAX = longint'(DIM_CAP) * longint'(DIM_CAP);
  localparam int TOTAL_W   = $clog2(TOTAL_MAX + 1);
  localparam logic [pfrgba_pkg::DIM_W-1:0] DIM_CAP_V = pfrgba_pkg::DIM_W'(DIM_CAP);

  logic [pfrgba_pkg::FMT_W-1:0]    source_format, source_format_next;
  logic [pfrgba_pkg::DIM_W-1:0]    image_width, image_width_next;
  logic [pfrgba_pkg::DIM_W-1:0]    image_height, image_height_next;
  logic [pfrgba_pkg::DIM_W-1:0]    width_clamped, height_clamped;
  logic [2*pfrgba_pkg::DIM_W-1:0]  area;
  logic [TOTAL_W-1:0]              total_pixels;

  logic [pfrgba_pkg::GATHER_W-1:0] gathered_bytes;
  logic [1:0]                      byte_position;
  logic [TOTAL_W-1:0]              pixel_count;

  logic                            accept;
  logic                            unsupported;
  logic [1:0]                      last_position;
  logic                            complete;
  logic [pfrgba_pkg::WORD_W-1:0]   word;
  logic [TOTAL_W:0]                count_plus;
  logic                            is_last;
  logic                            push;
  pfrgba_pkg::pixel_t              pixel;
  pfrgba_pkg::pixel_t              out_data;

  assign accept = in_valid && !in_stall;

  // Register write decode.
  always_comb begin
    source_format_next = source_format;
    image_width_next   = image_width;
    image_height_next  = image_height;
    if (cfg_write) begin
      unique case (cfg_index)
        pfrgba_pkg::REG_SOURCE_FORMAT: source_format_next = cfg_data[pfrgba_pkg::FMT_W-1:0];
        pfrgba_pkg::REG_IMAGE_WIDTH:   image_width_next   = cfg_data;
        pfrgba_pkg::REG_IMAGE_HEIGHT:  image_height_next  = cfg_data;
        default: ;
      endcase
    end
  end

  // Dimensions of zero count as one, large ones are capped.
  always_comb begin
    if (image_width_next == '0) begin
      width_clamped = pfrgba_pkg::DIM_W'(1);
    end else if (image_width_next > DIM_CAP_V) begin
      width_clamped = DIM_CAP_V;
    end else begin
      width_clamped = image_width_next;
    end
    if (image_height_next == '0) begin
      height_clamped = pfrgba_pkg::DIM_W'(1);
    end else if (image_height_next > DIM_CAP_V) begin
      height_clamped = DIM_CAP_V;
    end else begin
      height_clamped = image_height_next;
    end
  end

  assign area = width_clamped * height_clamped;

  // Configuration registers and the registered pixel total.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= pfrgba_pkg::FMT_RGBA;
      image_width   <= pfrgba_pkg::DIM_W'(1);
      image_height  <= pfrgba_pkg::DIM_W'(1);
      total_pixels  <= TOTAL_W'(1);
    end else begin
      source_format <= source_format_next;
      image_width   <= image_width_next;
      image_height  <= image_height_next;
      total_pixels  <= area[TOTAL_W-1:0];
    end
  end

  // Bytes per pixel for the current format, as the position of the final byte.
  assign unsupported = source_format[pfrgba_pkg::FMT_W-1];
  always_comb begin
    if (source_format <= pfrgba_pkg::FMT_ARGB) begin
      last_position = 2'd3;
    end else if (source_format <= pfrgba_pkg::FMT_RGB) begin
      last_position = 2'd2;
    end else begin
      last_position = 2'd1;
    end
  end

  assign complete = byte_position >= last_position;

  // Source word from the held bytes and the arriving byte.
  always_comb begin
    unique case (last_position)
      2'd3:    word = {in_byte, gathered_bytes};
      2'd2:    word = {8'h00, in_byte, gathered_bytes[15:0]};
      default: word = {16'h0000, in_byte, gathered_bytes[7:0]};
    endcase
  end

  // End of image detection.
  assign count_plus = {1'b0, pixel_count} + (TOTAL_W+1)'(1);
  assign is_last    = count_plus >= {1'b0, total_pixels};

  pfrgba_unpack u_unpack (
    .source_format (source_format),
    .word          (word),
    .last_pixel    (is_last && !unsupported),
    .pixel         (pixel)
  );

  // Gather state and pixel count.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      byte_position <= '0;
      pixel_count   <= '0;
    end else if (accept && !unsupported) begin
      if (complete) begin
        byte_position <= '0;
        pixel_count   <= is_last ? '0 : count_plus[TOTAL_W-1:0];
      end else begin
        byte_position <= byte_position + 2'd1;
      end
    end
  end

  // Held bytes of the current pixel; unused positions are masked off above.
  always_ff @(posedge clk) begin
    if (accept && !unsupported && !complete) begin
      unique case (byte_position)
        2'd0:    gathered_bytes[7:0]   <= in_byte;
        2'd1:    gathered_bytes[15:8]  <= in_byte;
        default: gathered_bytes[23:16] <= in_byte;
      endcase
    end
  end

  assign push = accept && (unsupported || complete);

  pfrgba_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (pixel),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (in_stall)
  );

  assign red          = out_data.red;
  assign green        = out_data.green;
  assign blue         = out_data.blue;
  assign alpha        = out_data.alpha;
  assign last_pixel   = out_data.last_pixel;
  assign format_error = out_data.format_error;

  // The input is only held back while a result is already waiting.
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

  // An error transaction carries no colour and no end of image mark.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && format_error) |->
      (red == '0 && green == '0 && blue == '0 && alpha == '0 && !last_pixel))
    else $error("error transaction with non-zero payload");

  // The pixel count stays below the image size.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    pixel_count < total_pixels)
    else $error("pixel count reached the image size");

  // A register write restarts pixel gathering.
  a_write_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (byte_position == '0 && pixel_count == '0))
    else $error("gather state survived a register write");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the byte stream to RGBA8 pixel converter against its own prediction.
// A short table of directed steps covers every source format, the channel
// extremes, the clamped image sizes, a dropped partial pixel and the
// unsupported format. Random phases follow: each writes fresh registers and
// streams random bytes. Both channels pause in random bursts.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 1020;
  localparam int CALM_ITEMS    = 150;
  localparam int MAX_GAP       = 18;
  localparam logic [pfrgba_pkg::FMT_W-1:0]     FMT_UNSUPPORTED = 4'hF;
  localparam logic [pfrgba_pkg::CFG_IDX_W-1:0] REG_SPARE       = 2'd3;

  typedef enum logic {STEP_CFG, STEP_BYTE} step_kind_t;

  // One row of the directed table: a register write or one source byte.
  typedef struct {
    step_kind_t                       kind;
    logic [pfrgba_pkg::CFG_IDX_W-1:0] idx;
    logic [pfrgba_pkg::DIM_W-1:0]     data;
    logic [pfrgba_pkg::BYTE_W-1:0]    value;
    bit                               typed;
    pfrgba_pkg::pixel_t               want;
  } step_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [pfrgba_pkg::BYTE_W-1:0]    in_byte = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [pfrgba_pkg::BYTE_W-1:0]    red, green, blue, alpha;
  logic                             last_pixel, format_error;
  logic                             cfg_write = 1'b0;
  logic [pfrgba_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pfrgba_pkg::DIM_W-1:0]     cfg_data = '0;

  // Predicted converter state and configuration.
  logic [pfrgba_pkg::FMT_W-1:0]    src_fmt = pfrgba_pkg::FMT_RGBA;
  logic [pfrgba_pkg::DIM_W-1:0]    img_w = 13'd1;
  logic [pfrgba_pkg::DIM_W-1:0]    img_h = 13'd1;
  logic [pfrgba_pkg::GATHER_W-1:0] gather = '0;
  int unsigned                     pos = 0;
  int unsigned                     pix_count = 0;

  pfrgba_pkg::pixel_t pending_pixels[$];
  step_t              directed_steps[$];
  int     mismatches = 0;
  int     quiet_cycles = 0;
  int     send_gap_pct = 0;
  int     recv_stall_pct = 0;
  int     stall_left = 0;

  pixel_format_to_rgba8_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .last_pixel   (last_pixel),
    .format_error (format_error),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // A dimension of zero counts as one; anything above the maximum is clamped.
  function automatic int unsigned clamped_dim(input logic [pfrgba_pkg::DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > pfrgba_pkg::DEFAULT_MAX_DIMENSION) return pfrgba_pkg::DEFAULT_MAX_DIMENSION;
    return 32'(v);
  endfunction

  // Takes one source byte; returns 1 and the pixel when the byte completes one.
  function automatic bit convert_byte(input logic [pfrgba_pkg::BYTE_W-1:0] value,
                                      output pfrgba_pkg::pixel_t px);
    int unsigned need;
    int unsigned total;
    logic [pfrgba_pkg::WORD_W-1:0] word;
    px = '0;
    if (src_fmt > pfrgba_pkg::FMT_A4R4G4B4) begin
      px.format_error = 1'b1;
      return 1'b1;
    end
    case (src_fmt)
      pfrgba_pkg::FMT_BGRA, pfrgba_pkg::FMT_RGBA,
      pfrgba_pkg::FMT_ABGR, pfrgba_pkg::FMT_ARGB: need = 4;
      pfrgba_pkg::FMT_BGR, pfrgba_pkg::FMT_RGB:   need = 3;
      default:                                    need = 2;
    endcase
    if (pos + 1 < need) begin
      gather[8*pos +: 8] = value;
      pos = pos + 1;
      return 1'b0;
    end
    word = '0;
    for (int k = 0; k < need - 1; k++) begin
      word[8*k +: 8] = gather[8*k +: 8];
    end
    word[8*(need-1) +: 8] = value;
    gather = '0;
    pos = 0;
    px.alpha = 8'hFF;
    case (src_fmt)
      pfrgba_pkg::FMT_BGRA:   {px.alpha, px.red, px.green, px.blue} = word;
      pfrgba_pkg::FMT_RGBA:   {px.alpha, px.blue, px.green, px.red} = word;
      pfrgba_pkg::FMT_ABGR:   {px.red, px.green, px.blue, px.alpha} = word;
      pfrgba_pkg::FMT_ARGB:   {px.blue, px.green, px.red, px.alpha} = word;
      pfrgba_pkg::FMT_BGR:    {px.red, px.green, px.blue} = word[23:0];
      pfrgba_pkg::FMT_RGB:    {px.blue, px.green, px.red} = word[23:0];
      pfrgba_pkg::FMT_R5G6B5: begin
        px.blue  = 8'((int'(word[4:0]) * 255) / 31);
        px.green = 8'((int'(word[10:5]) * 255) / 63);
        px.red   = 8'((int'(word[15:11]) * 255) / 31);
      end
      default: begin
        px.blue  = 8'(int'(word[3:0]) * 17);
        px.green = 8'(int'(word[7:4]) * 17);
        px.red   = 8'(int'(word[11:8]) * 17);
        px.alpha = 8'(int'(word[15:12]) * 17);
      end
    endcase
    total = clamped_dim(img_w) * clamped_dim(img_h);
    px.last_pixel = (pix_count + 1 >= total);
    pix_count = px.last_pixel ? 0 : pix_count + 1;
    return 1'b1;
  endfunction

  function automatic void add_byte(input logic [pfrgba_pkg::BYTE_W-1:0] value);
    directed_steps.insert(directed_steps.size(), '{STEP_BYTE, '0, '0, value, 1'b0, '0});
  endfunction

  // The wanted pixel is packed as red, green, blue, alpha, last, error.
  function automatic void add_typed(input logic [pfrgba_pkg::BYTE_W-1:0] value,
                                    input pfrgba_pkg::pixel_t want);
    directed_steps.insert(directed_steps.size(), '{STEP_BYTE, '0, '0, value, 1'b1, want});
  endfunction

  function automatic void add_write(input logic [pfrgba_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [pfrgba_pkg::DIM_W-1:0] data);
    directed_steps.insert(directed_steps.size(), '{STEP_CFG, idx, data, '0, 1'b0, '0});
  endfunction

  // Presents one byte, waits for its transaction and records any pixel due.
  task automatic send_byte(input logic [pfrgba_pkg::BYTE_W-1:0] value, input bit typed,
                           input pfrgba_pkg::pixel_t want);
    pfrgba_pkg::pixel_t px;
    bit                 has_px;
    cfg_write <= 1'b0;
    in_valid  <= 1'b1;
    in_byte   <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    has_px = convert_byte(value, px);
    if (has_px) pending_pixels.insert(pending_pixels.size(), typed ? want : px);
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
  endtask

  // Holds the sender until every pixel has arrived and the block is quiet.
  task automatic wait_until_drained();
    in_valid  <= 1'b0;
    cfg_write <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes one register; the caller keeps the block idle around it.
  task automatic write_register(input logic [pfrgba_pkg::CFG_IDX_W-1:0] idx,
                                input logic [pfrgba_pkg::DIM_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      pfrgba_pkg::REG_SOURCE_FORMAT: src_fmt = value[pfrgba_pkg::FMT_W-1:0];
      pfrgba_pkg::REG_IMAGE_WIDTH:   img_w = value;
      pfrgba_pkg::REG_IMAGE_HEIGHT:  img_h = value;
      default: ;
    endcase
    gather    = '0;
    pos       = 0;
    pix_count = 0;
  endtask

  function automatic logic [pfrgba_pkg::DIM_W-1:0] random_dim(input int small_max);
    if ($urandom_range(0, 9) != 0)
      return pfrgba_pkg::DIM_W'($urandom_range(0, small_max));
    case ($urandom_range(0, 3))
      0:       return 13'd4096;
      1:       return 13'd4097;
      2:       return 13'h1FFF;
      default: return pfrgba_pkg::DIM_W'($urandom);
    endcase
  endfunction

  // Receiver stalls in random bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!rst && $urandom_range(0, 99) < recv_stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, MAX_GAP - 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Each pixel transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    pfrgba_pkg::pixel_t got;
    pfrgba_pkg::pixel_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {red, green, blue, alpha, last_pixel, format_error};
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel r=%h g=%h b=%h a=%h last=%b err=%b",
                   got.red, got.green, got.blue, got.alpha, got.last_pixel,
                   got.format_error);
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.alpha !== want.alpha ||
            got.last_pixel !== want.last_pixel ||
            got.format_error !== want.format_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected %h %h %h %h %b %b, got %h %h %h %h %b %b",
                     want.red, want.green, want.blue, want.alpha, want.last_pixel,
                     want.format_error, got.red, got.green, got.blue, got.alpha,
                     got.last_pixel, got.format_error);
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int                           sent;
    int                           len;
    int                           pick;
    bit                           pause;
    logic [pfrgba_pkg::FMT_W-1:0] code;

    // Directed table. After reset the block unpacks RGBA for a 1x1 image.
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_typed(8'h00, {8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0});
    add_write(pfrgba_pkg::REG_SOURCE_FORMAT, pfrgba_pkg::DIM_W'(pfrgba_pkg::FMT_BGRA));
    add_byte(8'h01);
    add_byte(8'h02);
    add_byte(8'h03);
    add_typed(8'h04, {8'h03, 8'h02, 8'h01, 8'h04, 1'b1, 1'b0});
    add_write(pfrgba_pkg::REG_SOURCE_FORMAT, pfrgba_pkg::DIM_W'(pfrgba_pkg::FMT_ABGR));
    add_byte(8'h5A);
    add_byte(8'hC3);
    add_byte(8'h3C);
    add_byte(8'hA5);
    add_write(pfrgba_pkg::REG_SOURCE_FORMAT, pfrgba_pkg::DIM_W'(pfrgba_pkg::FMT_ARGB));
    add_byte(8'h80);
    add_byte(8'h7F);
    add_byte(8'h01);
    add_byte(8'hFE);
    // Width zero counts as one, so a height of two makes a two pixel image.
    add_write(pfrgba_pkg::REG_SOURCE_FORMAT, pfrgba_pkg::DIM_W'(pfrgba_pkg::FMT_BGR));
    add_write(pfrgba_pkg::REG_IMAGE_WIDTH, 13'd0);
    add_write(pfrgba_pkg::REG_IMAGE_HEIGHT, 13'd2);
    add_byte(8'h00);
    add_byte(8'h00);
    add_typed(8'h00, {8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0});
    add_byte(8'h12);
    add_byte(8'h34);
    add_byte(8'h56);
    // Width one above the maximum is clamped to it.
    add_write(pfrgba_pkg::REG_SOURCE_FORMAT, pfrgba_pkg::DIM_W'(pfrgba_pkg::FMT_RGB));
    add_write(pfrgba_pkg::REG_IMAGE_WIDTH, 13'd4097);
    add_write(pfrgba_pkg::REG_IMAGE_HEIGHT, 13'd1);
    add_byte(8'h9A);
    add_byte(8'hBC);
    add_byte(8'hDE);
    // A write to the spare index must drop the half gathered pixel.
    add_write(pfrgba_pkg::REG_SOURCE_FORMAT, pfrgba_pkg::DIM_W'(pfrgba_pkg::FMT_R5G6B5));
    add_byte(8'h00);
    add_write(REG_SPARE, 13'h1FFF);
    add_byte(8'hFF);
    add_typed(8'hFF, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0});
    add_write(pfrgba_pkg::REG_SOURCE_FORMAT,
              pfrgba_pkg::DIM_W'(pfrgba_pkg::FMT_A4R4G4B4));
    add_byte(8'h00);
    add_typed(8'hFF, {8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0});
    add_write(pfrgba_pkg::REG_SOURCE_FORMAT, pfrgba_pkg::DIM_W'(FMT_UNSUPPORTED));
    add_typed(8'hA5, {8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct   = 20;
    recv_stall_pct = 20;
    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_CFG) begin
        wait_until_drained();
        write_register(directed_steps[i].idx, directed_steps[i].data);
      end else begin
        send_byte(directed_steps[i].value, directed_steps[i].typed,
                  directed_steps[i].want);
      end
    end

    // Random phases: new registers at an idle point, then a burst of bytes.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_until_drained();
      pick = $urandom_range(0, 9);
      code = (pick < 8) ? pfrgba_pkg::FMT_W'(pick)
                        : pfrgba_pkg::FMT_W'($urandom_range(8, 15));
      write_register(pfrgba_pkg::REG_SOURCE_FORMAT,
                     {pfrgba_pkg::DIM_W'($urandom) >> pfrgba_pkg::FMT_W
                      << pfrgba_pkg::FMT_W} | code);
      if ($urandom_range(0, 1) != 0)
        write_register(pfrgba_pkg::REG_IMAGE_WIDTH, random_dim(6));
      if ($urandom_range(0, 1) != 0)
        write_register(pfrgba_pkg::REG_IMAGE_HEIGHT, random_dim(4));
      if ($urandom_range(0, 7) == 0) write_register(REG_SPARE, pfrgba_pkg::DIM_W'($urandom));

      if (sent >= RANDOM_ITEMS - CALM_ITEMS) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       send_gap_pct = 0;
          1:       send_gap_pct = 5;
          default: send_gap_pct = 25;
        endcase
        case ($urandom_range(0, 3))
          0:       recv_stall_pct = 0;
          1:       recv_stall_pct = 5;
          default: recv_stall_pct = 25;
        endcase
      end

      len   = (code > pfrgba_pkg::FMT_A4R4G4B4) ? $urandom_range(8, 20)
                                                : $urandom_range(20, 90);
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      pause = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        // Now and then the sender waits for the output side to empty.
        if (pause && k == len / 2) wait_until_drained();
        send_byte(pfrgba_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
        sent++;
      end
    end

    wait_until_drained();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pfrgba_pkg.sv
src/pfrgba_unpack.sv
src/pfrgba_outbuf.sv
src/pixel_format_to_rgba8_top.sv
tb/tb_top.sv
